FILE: rtl/toost_pkg.sv
`timescale 1ns / 1ps
package toost_pkg;
    localparam int TableDepth = 32;
    localparam int SeqW = 32;
    localparam int LenW = 16;
    localparam int TagW = 48;
    localparam int AckW = 32;

    typedef logic [2:0] t_cmd;
    localparam t_cmd CmdInsert = 3'd0;
    localparam t_cmd CmdLocate = 3'd1;
    localparam t_cmd CmdFind   = 3'd2;
    localparam t_cmd CmdDrain  = 3'd3;
    localparam t_cmd CmdClear  = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status StOk   = 2'd0;
    localparam t_status StDup  = 2'd1;
    localparam t_status StFull = 2'd2;
    localparam t_status StMiss = 2'd3;

    typedef struct packed {
        logic [SeqW-1:0] seq;
        logic [LenW-1:0] len;
        logic [TagW-1:0] tag;
        logic [AckW-1:0] ack;
    } t_entry;

    // broadcast from control to every cell
    typedef struct packed {
        logic            shift_en;  // insert: cells after pos take left neighbour
        logic            write_en;  // insert: cell at pos takes new entry
        logic [SeqW-1:0] key;
    } t_cell_ctl;

    // wrap-aware a before b
    function automatic logic seq_before(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
        logic [SeqW-1:0] d;
        d = a - b;
        return d[SeqW-1];
    endfunction
endpackage

FILE: rtl/toost_cell.sv
`timescale 1ns / 1ps
module toost_cell (
    input  logic                  i_clk,
    input  logic                  i_valid,
    input  toost_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_at_pos,
    input  logic                  i_after_pos,
    input  toost_pkg::t_entry     i_left,
    input  toost_pkg::t_entry     i_new,
    output toost_pkg::t_entry     o_entry,
    output logic                  o_eq,
    output logic                  o_key_before,
    output logic                  o_not_before_key
);
    import toost_pkg::*;

    t_entry r_entry;

    // shift / write per cell
    always_ff @(posedge i_clk) begin
        if (i_ctl.write_en && i_at_pos) begin
            r_entry <= i_new;
        end else if (i_ctl.shift_en && i_after_pos) begin
            r_entry <= i_left;
        end
    end

    // per-cell compare against key, masked by occupancy
    assign o_entry          = r_entry;
    assign o_eq             = i_valid && (r_entry.seq == i_ctl.key);
    assign o_key_before     = i_valid && seq_before(i_ctl.key, r_entry.seq);
    assign o_not_before_key = i_valid && !seq_before(r_entry.seq, i_ctl.key);
endmodule

FILE: rtl/tcp_out_of_order_segment_table_core.sv
`timescale 1ns / 1ps
// Sorted table of TCP segment descriptors held in a chain of cells, one entry per
// cell, kept in wrap-aware sequence order. Each item is one command: insert,
// locate, find, drain or clear. Every cell compares its sequence against the key
// in parallel; a registered priority pick then selects the position. Insert,
// locate, find, clear and unknown commands pass the compare, execute and output
// states in turn, and the next item is taken once the result has been handed over.
// Drain emits one result per entry while the output is ready, up to the budget and
// at most 32 entries; an empty table or a zero budget gives a single miss result.
// The block handles one item at a time.
module tcp_out_of_order_segment_table_core #(
    parameter int TABLE_DEPTH = toost_pkg::TableDepth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[2:0], seq_number[34:3], seg_length[50:35], packet_tag[98:51],
    // ack_number[130:99], budget[162:131], zero pad
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], entry_index[6:2], entry_seq[38:7], entry_length[54:39],
    // entry_packet[102:55], entry_ack[134:103], chunk_offset[166:135],
    // chunk_length[182:167], entry_count[188:183], zero pad
    output logic [191:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import toost_pkg::*;

    localparam int IdxW = $clog2(TABLE_DEPTH);
    localparam int CntW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_CMP, S_EXEC, S_DRAIN, S_OUT} t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    t_entry            r_new;
    logic [31:0]       r_budget, r_used;
    logic [CntW-1:0]   r_count, r_pos, r_dup_pos, r_hit_pos;
    logic              r_dup, r_hit;
    logic [IdxW-1:0]   r_di;
    logic [1:0]        r_st;
    logic [4:0]        r_oidx;
    t_entry            r_oent;
    logic [31:0]       r_ooff;
    logic [15:0]       r_olen;
    logic              r_olast;

    t_cell_ctl         w_ctl;
    t_entry            w_ent [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_eq, w_kb, w_nb;

    // cell chain
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        toost_cell u_cell (
            .i_clk            (i_clk),
            .i_valid          (CntW'(g) < r_count),
            .i_ctl            (w_ctl),
            .i_at_pos         (CntW'(g) == r_pos),
            .i_after_pos      (CntW'(g) > r_pos),
            .i_left           (g == 0 ? r_new : w_ent[(g == 0) ? 0 : g - 1]),
            .i_new            (r_new),
            .o_entry          (w_ent[g]),
            .o_eq             (w_eq[g]),
            .o_key_before     (w_kb[g]),
            .o_not_before_key (w_nb[g])
        );
    end

    logic w_do_ins;
    assign w_do_ins = (r_state == S_EXEC) && (r_cmd == CmdInsert) && !r_dup
                      && (r_count < CntW'(TABLE_DEPTH));
    assign w_ctl.key      = r_new.seq;
    assign w_ctl.shift_en = w_do_ins;
    assign w_ctl.write_en = w_do_ins;

    // priority picks: first eq, first key-before, first hit
    logic [CntW-1:0] w_first_eq, w_first_kb, w_first_hit;
    logic            w_any_eq_pre, w_any_hit;
    logic [TABLE_DEPTH-1:0] w_hitv;
    assign w_hitv = (r_cmd == CmdLocate) ? w_nb : w_eq;
    always_comb begin
        w_first_eq  = CntW'(TABLE_DEPTH);
        w_first_kb  = r_count;
        w_first_hit = CntW'(TABLE_DEPTH);
        for (int k = TABLE_DEPTH - 1; k >= 0; k--) begin
            if (w_eq[k])   w_first_eq  = CntW'(k);
            if (w_kb[k])   w_first_kb  = CntW'(k);
            if (w_hitv[k]) w_first_hit = CntW'(k);
        end
        // duplicate counts only if seen at or before the place
        w_any_eq_pre = (w_first_eq != CntW'(TABLE_DEPTH)) && (w_first_eq <= w_first_kb);
        w_any_hit    = (w_first_hit != CntW'(TABLE_DEPTH));
    end

    // drain step values
    t_entry      w_de;
    logic [31:0] w_avail, w_chunk;
    assign w_de    = w_ent[r_di];
    assign w_avail = r_budget - r_used;
    assign w_chunk = ({16'd0, w_de.len} > w_avail) ? w_avail : {16'd0, w_de.len};

    // control and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (s_axis_tvalid) begin
                    r_cmd     <= s_axis_tdata[2:0];
                    r_new.seq <= s_axis_tdata[34:3];
                    r_new.len <= s_axis_tdata[50:35];
                    r_new.tag <= s_axis_tdata[98:51];
                    r_new.ack <= s_axis_tdata[130:99];
                    r_budget  <= s_axis_tdata[162:131];
                    r_state   <= S_CMP;
                end
                S_CMP: begin
                    r_dup     <= w_any_eq_pre;
                    r_dup_pos <= w_first_eq;
                    r_pos     <= w_first_kb;
                    r_hit     <= w_any_hit;
                    r_hit_pos <= w_first_hit;
                    r_state   <= S_EXEC;
                end
                S_EXEC: begin
                    r_ooff  <= '0;
                    r_olen  <= '0;
                    r_olast <= 1'b1;
                    r_oidx  <= '0;
                    r_oent  <= '0;
                    r_st    <= StMiss;
                    r_state <= S_OUT;
                    case (r_cmd)
                        CmdInsert: begin
                            if (r_dup) begin
                                r_st   <= StDup;
                                r_oidx <= 5'(r_dup_pos);
                                r_oent <= w_ent[r_dup_pos[IdxW-1:0]];
                            end else if (r_count >= CntW'(TABLE_DEPTH)) begin
                                r_st   <= StFull;
                                r_oent <= r_new;
                            end else begin
                                r_st    <= StOk;
                                r_oidx  <= 5'(r_pos);
                                r_oent  <= r_new;
                                r_count <= r_count + 1'b1;
                            end
                        end
                        CmdLocate, CmdFind: begin
                            if (r_hit) begin
                                r_st   <= StOk;
                                r_oidx <= 5'(r_hit_pos);
                                r_oent <= w_ent[r_hit_pos[IdxW-1:0]];
                            end
                        end
                        CmdDrain: begin
                            if (r_count != '0 && r_budget != '0) begin
                                r_di    <= '0;
                                r_used  <= '0;
                                r_state <= S_DRAIN;
                            end
                        end
                        CmdClear: begin
                            r_st    <= StOk;
                            r_count <= '0;
                        end
                        default: ;
                    endcase
                end
                S_DRAIN: begin
                    r_st    <= StOk;
                    r_oidx  <= 5'(r_di);
                    r_oent  <= w_de;
                    r_ooff  <= r_used;
                    r_olen  <= w_chunk[15:0];
                    r_used  <= r_used + w_chunk;
                    r_olast <= (CntW'(r_di) + 1'b1 >= r_count)
                               || (r_used + w_chunk >= r_budget)
                               || (6'(r_di) >= 6'd31);
                    r_state <= S_OUT;
                end
                S_OUT: if (m_axis_tready) begin
                    if (r_olast) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_di    <= r_di + 1'b1;
                        r_state <= S_DRAIN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {3'd0, 6'(r_count), r_olen, r_ooff, r_oent.ack, r_oent.tag,
                            r_oent.len, r_oent.seq, r_oidx, r_st};
endmodule

FILE: tb/sv/tcp_out_of_order_segment_table_core_tb.sv
`timescale 1ns / 1ps
module tcp_out_of_order_segment_table_core_tb;
    import toost_pkg::*;

    localparam int IdleLimit  = 5000;
    localparam int HoldCycles = 300;
    localparam int MaxDrain   = 32;

    // one expected result item
    typedef struct {
        t_status     st;
        logic [4:0]  idx;
        t_entry      ent;
        logic [31:0] off;
        logic [15:0] clen;
        logic [5:0]  cnt;
        logic        last;
    } t_seg_report;

    // predicts the sorted segment table and checks each result item
    class seg_table_scoreboard;
        t_entry      table_q[$];
        t_seg_report expected_q[$];
        int          fail_count;

        function new();
            fail_count = 0;
        endfunction

        // wrap-aware ordering of two sequence numbers
        function bit seq_earlier(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return d[31];
        endfunction

        function void push_report(t_status st, logic [4:0] idx, t_entry ent,
                                  logic [31:0] off, logic [15:0] clen, logic last);
            t_seg_report r;
            r.st = st; r.idx = idx; r.ent = ent; r.off = off; r.clen = clen;
            r.cnt = 6'(table_q.size()); r.last = last;
            expected_q.push_back(r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [31:0] held_seq();
            if (table_q.size() == 0) return $urandom;
            return table_q[$urandom_range(0, table_q.size() - 1)].seq;
        endfunction

        // work out the result items of one accepted command
        function void note_command(t_cmd cmd, t_entry ne, logic [31:0] budget);
            int          n, pos, k;
            logic [31:0] used, avail, chunk;
            t_entry      zero_ent;
            zero_ent = '0;
            n = table_q.size();
            case (cmd)
                CmdInsert: begin
                    pos = n;
                    for (int i = 0; i < n; i++) begin
                        if (table_q[i].seq == ne.seq) begin
                            push_report(StDup, 5'(i), table_q[i], '0, '0, 1'b1);
                            return;
                        end
                        if (seq_earlier(ne.seq, table_q[i].seq)) begin
                            pos = i;
                            break;
                        end
                    end
                    if (n >= TableDepth) begin
                        push_report(StFull, '0, ne, '0, '0, 1'b1);
                        return;
                    end
                    table_q.insert(pos, ne);
                    push_report(StOk, 5'(pos), ne, '0, '0, 1'b1);
                end
                CmdLocate, CmdFind: begin
                    for (int i = 0; i < n; i++) begin
                        if ((cmd == CmdLocate) ? !seq_earlier(table_q[i].seq, ne.seq)
                                               : (table_q[i].seq == ne.seq)) begin
                            push_report(StOk, 5'(i), table_q[i], '0, '0, 1'b1);
                            return;
                        end
                    end
                    push_report(StMiss, '0, zero_ent, '0, '0, 1'b1);
                end
                CmdDrain: begin
                    used = 0;
                    k = 0;
                    for (int i = 0; i < n && used < budget && k < MaxDrain; i++) begin
                        chunk = {16'd0, table_q[i].len};
                        avail = budget - used;
                        if (chunk > avail) chunk = avail;
                        push_report(StOk, 5'(i), table_q[i], used, chunk[15:0], 1'b0);
                        used += chunk;
                        k++;
                    end
                    if (k == 0) push_report(StMiss, '0, zero_ent, '0, '0, 1'b1);
                    else expected_q[expected_q.size() - 1].last = 1'b1;
                end
                CmdClear: begin
                    table_q.delete();
                    push_report(StOk, '0, zero_ent, '0, '0, 1'b1);
                end
                default: push_report(StMiss, '0, zero_ent, '0, '0, 1'b1);
            endcase
        endfunction

        // compare one result item with the oldest expectation
        function void check_result(logic [191:0] d, logic last);
            t_seg_report e;
            bit          bad;
            if (expected_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) $display("ERROR unexpected result item %h", d);
                return;
            end
            e = expected_q.pop_front();
            bad = (d[1:0] != e.st) || (d[6:2] != e.idx) || (d[38:7] != e.ent.seq)
                || (d[54:39] != e.ent.len) || (d[102:55] != e.ent.tag)
                || (d[134:103] != e.ent.ack) || (d[166:135] != e.off)
                || (d[182:167] != e.clen) || (d[188:183] != e.cnt) || (last != e.last);
            if (bad) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display({"ERROR exp st=%0d idx=%0d seq=%h len=%h tag=%h ack=%h",
                              " off=%h clen=%h cnt=%0d last=%b"},
                             e.st, e.idx, e.ent.seq, e.ent.len, e.ent.tag, e.ent.ack,
                             e.off, e.clen, e.cnt, e.last);
                    $display({"      got st=%0d idx=%0d seq=%h len=%h tag=%h ack=%h",
                              " off=%h clen=%h cnt=%0d last=%b"},
                             d[1:0], d[6:2], d[38:7], d[54:39], d[102:55], d[134:103],
                             d[166:135], d[182:167], d[188:183], last);
                end
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // command, seq_number, seg_length, packet_tag, ack_number, budget, zero pad
    logic [167:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // status, entry_index, entry_seq, entry_length, entry_packet, entry_ack,
    // chunk_offset, chunk_length, entry_count, zero pad
    logic [191:0] m_axis_tdata;
    logic         m_axis_tlast;

    seg_table_scoreboard sb;
    bit hold_req;
    bit calm_tx;
    bit calm_rx;
    int idle_cycles = 0;

    tcp_out_of_order_segment_table_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // check each accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IdleLimit) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls and one long hold-off
    initial begin
        int g;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
            end
            g = calm_rx ? 0 : $urandom_range(0, 15);
            if (g > 0) begin
                m_axis_tready <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // offer one command item and wait for its acceptance
    task automatic send_cmd(t_cmd cmd, logic [31:0] seq, logic [15:0] len,
                            logic [47:0] tag, logic [31:0] ack, logic [31:0] budget);
        int     g;
        t_entry ne;
        g = calm_tx ? 0 : $urandom_range(0, 15);
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, budget, ack, tag, len, seq, cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        ne.seq = seq; ne.len = len; ne.tag = tag; ne.ack = ack;
        sb.note_command(cmd, ne, budget);
        @(negedge i_clk);
    endtask

    task automatic insert_seg(logic [31:0] seq, logic [15:0] len);
        send_cmd(CmdInsert, seq, len, 48'({$urandom, $urandom}), $urandom, $urandom);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // random session: fill around a base, query, drain, unknown commands and clear
    task automatic run_session(int items);
        logic [31:0] base, key, bud;
        logic [15:0] len;
        int          pick;
        base = $urandom;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
            if (pick < 55) begin
                key = ($urandom_range(0, 5) == 0) ? sb.held_seq()
                                                  : base + $urandom_range(0, 4000);
                insert_seg(key, len);
            end else if (pick < 65) begin
                insert_seg($urandom, len);
            end else if (pick < 80) begin
                key = $urandom_range(0, 1) ? sb.held_seq() : base + $urandom_range(0, 4000);
                send_cmd($urandom_range(0, 1) ? CmdLocate : CmdFind, key, len,
                         48'({$urandom, $urandom}), $urandom, $urandom);
            end else if (pick < 93) begin
                case ($urandom_range(0, 3))
                    0: bud = 0;
                    1: bud = $urandom_range(1, 200000);
                    2: bud = 32'hFFFF_FFFF;
                    default: bud = $urandom;
                endcase
                send_cmd(CmdDrain, $urandom, len, 48'({$urandom, $urandom}), $urandom, bud);
            end else if (pick < 97) begin
                send_cmd(t_cmd'($urandom_range(5, 7)), $urandom, len,
                         48'({$urandom, $urandom}), $urandom, $urandom);
            end else begin
                send_cmd(CmdClear, $urandom, len, 48'({$urandom, $urandom}), $urandom,
                         $urandom);
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        sb = new();
        hold_req = 1'b0;
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty table, extremes, wrap, duplicate, zero length, unknown
        send_cmd(CmdDrain, 32'h0, 16'h0, 48'h0, 32'h0, 32'hFFFF_FFFF);
        send_cmd(CmdLocate, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_cmd(CmdFind, 32'h0, 16'h0, 48'h0, 32'h0, 0);
        send_cmd(CmdInsert, 32'hFFFF_FFF0, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_cmd(CmdInsert, 32'h0000_0010, 16'h0, 48'h0, 32'h0, 32'hFFFF_FFFF);
        send_cmd(CmdInsert, 32'h8000_0000, 16'd100, 48'h1234_5678_9ABC, 32'h5A5A_A5A5, 0);
        send_cmd(CmdInsert, 32'hFFFF_FFF0, 16'd7, 48'h1, 32'h1, 0);
        send_cmd(CmdInsert, 32'h0000_0000, 16'd0, 48'h2, 32'h2, 0);
        send_cmd(CmdLocate, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_cmd(CmdFind, 32'h0000_0010, 0, 0, 0, 0);
        send_cmd(CmdFind, 32'h0000_0011, 0, 0, 0, 0);
        send_cmd(CmdDrain, 0, 0, 0, 0, 32'd0);
        send_cmd(CmdDrain, 0, 0, 0, 0, 32'd10);
        send_cmd(CmdDrain, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_cmd(t_cmd'(5), 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
        send_cmd(t_cmd'(6), 0, 0, 0, 0, 0);
        send_cmd(t_cmd'(7), 0, 0, 0, 0, 0);
        send_cmd(CmdClear, 0, 0, 0, 0, 0);

        // fill to the top, then a full insert, a duplicate insert and a full drain
        for (int i = 0; i < TableDepth; i++) insert_seg(32'h7FFF_FFF0 + 3 * i, 16'd50);
        insert_seg(32'h7FFF_FFF1, 16'd1);
        insert_seg(32'h7FFF_FFF3, 16'd1);
        send_cmd(CmdDrain, 0, 0, 0, 0, 32'hFFFF_FFFF);

        // sender pauses until every expected item has come
        wait_drained();
        send_cmd(CmdClear, 0, 0, 0, 0, 0);

        // long receiver hold-off while inserts keep coming
        calm_tx = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) insert_seg($urandom, 16'($urandom));
        calm_tx = 1'b0;

        // random sessions, some with no idling on either side
        for (int s = 0; s < 10; s++) begin
            calm_tx = (s % 4 == 1);
            calm_rx = (s % 3 == 2);
            send_cmd(CmdClear, 0, 0, 0, 0, 0);
            run_session(40);
        end
        calm_tx = 1'b0;
        calm_rx = 1'b0;

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

FILE: tcp_out_of_order_segment_table_core.f
rtl/toost_pkg.sv
rtl/toost_cell.sv
rtl/tcp_out_of_order_segment_table_core.sv
tb/sv/tcp_out_of_order_segment_table_core_tb.sv
